// ===== src/cap_pkg.sv =====
`default_nettype none
package cap_pkg;

	localparam int DIM_BITS_DEF = 14;
	localparam int MODE_W = 4;
	localparam int CANVAS_W_RESET = 1920;
	localparam int CANVAS_H_RESET = 1080;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index, taken from paddr[2].
	localparam logic REG_CANVAS_W = 1'b0;
	localparam logic REG_CANVAS_H = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_STRETCH       = 4'd0,
		MODE_FIT_CENTRE    = 4'd1,
		MODE_FIT_LEFT      = 4'd2,
		MODE_FIT_RIGHT     = 4'd3,
		MODE_FIT_TOP       = 4'd4,
		MODE_FIT_BOTTOM    = 4'd5,
		MODE_TOP_LEFT      = 4'd6,
		MODE_TOP_CENTRE    = 4'd7,
		MODE_TOP_RIGHT     = 4'd8,
		MODE_MID_LEFT      = 4'd9,
		MODE_CENTRE        = 4'd10,
		MODE_MID_RIGHT     = 4'd11,
		MODE_BOTTOM_LEFT   = 4'd12,
		MODE_BOTTOM_CENTRE = 4'd13,
		MODE_BOTTOM_RIGHT  = 4'd14,
		MODE_INVALID       = 4'd15
	} mode_t;

	typedef enum logic [1:0] {
		ALIGN_START,
		ALIGN_MID,
		ALIGN_END
	} align_t;

endpackage
`default_nettype wire

// ===== src/cap_req_if.sv =====
`default_nettype none
interface cap_req_if #(
	parameter int DIM_BITS = cap_pkg::DIM_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [cap_pkg::MODE_W-1:0] align_mode;
	logic [DIM_BITS-1:0]        asset_width;
	logic [DIM_BITS-1:0]        asset_height;

	modport source (output valid, align_mode, asset_width, asset_height, input ready);
	modport sink (input valid, align_mode, asset_width, asset_height, output ready);
endinterface
`default_nettype wire

// ===== src/cap_res_if.sv =====
`default_nettype none
interface cap_res_if #(
	parameter int DIM_BITS = cap_pkg::DIM_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic                placed_ok;
	logic [DIM_BITS-1:0] pos_x;
	logic [DIM_BITS-1:0] pos_y;
	logic [DIM_BITS-1:0] placed_width;
	logic [DIM_BITS-1:0] placed_height;

	modport source (output valid, placed_ok, pos_x, pos_y, placed_width, placed_height,
		input ready);
	modport sink (input valid, placed_ok, pos_x, pos_y, placed_width, placed_height,
		output ready);
endinterface
`default_nettype wire

// ===== src/cap_div_cell.sv =====
`default_nettype none
// One stage of the restoring divider: settles a single quotient bit.
module cap_div_cell #(
	parameter int DIM_BITS = cap_pkg::DIM_BITS_DEF,
	parameter int SIDE_W   = 1,
	parameter int BIT_POS  = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  valid_in,
	input  wire logic [2*DIM_BITS-1:0] rem_in,
	input  wire logic [DIM_BITS-1:0]   div_in,
	input  wire logic [DIM_BITS-1:0]   quo_in,
	input  wire logic [SIDE_W-1:0]     side_in,
	output logic                       valid_out,
	output logic [2*DIM_BITS-1:0]      rem_out,
	output logic [DIM_BITS-1:0]        div_out,
	output logic [DIM_BITS-1:0]        quo_out,
	output logic [SIDE_W-1:0]          side_out
);

	logic [2*DIM_BITS-1:0] trial;
	logic                  take;
	logic [2*DIM_BITS-1:0] rem_next;
	logic [DIM_BITS-1:0]   quo_next;
	logic                  valid_q;
	logic [2*DIM_BITS-1:0] rem_q;
	logic [DIM_BITS-1:0]   div_q;
	logic [DIM_BITS-1:0]   quo_q;
	logic [SIDE_W-1:0]     side_q;

	always_comb begin
		trial = (2*DIM_BITS)'(div_in) << BIT_POS;
		take = rem_in >= trial;
		rem_next = take ? rem_in - trial : rem_in;
		quo_next = quo_in;
		quo_next[BIT_POS] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_next;
			div_q <= div_in;
			quo_q <= quo_next;
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign rem_out = rem_q;
	assign div_out = div_q;
	assign quo_out = quo_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

// ===== src/cap_place.sv =====
`default_nettype none
// Final stage: picks the placed size, aligns it on the canvas and holds the result.
module cap_place #(
	parameter int DIM_BITS = cap_pkg::DIM_BITS_DEF,
	parameter int SIDE_W   = cap_pkg::MODE_W + 2*DIM_BITS + 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                valid_in,
	input  wire logic [DIM_BITS-1:0] quo_in,
	input  wire logic [SIDE_W-1:0]   side_in,
	input  wire logic [DIM_BITS-1:0] canvas_w,
	input  wire logic [DIM_BITS-1:0] canvas_h,
	cap_res_if.source                res
);

	cap_pkg::mode_t      mode;
	logic [DIM_BITS-1:0] aw;
	logic [DIM_BITS-1:0] ah;
	logic                fit_h;
	logic                ok;
	logic [DIM_BITS-1:0] w;
	logic [DIM_BITS-1:0] h;
	logic [DIM_BITS-1:0] x;
	logic [DIM_BITS-1:0] y;
	cap_pkg::align_t     ax;
	cap_pkg::align_t     ay;
	logic                valid_q;
	logic                ok_q;
	logic [DIM_BITS-1:0] x_q;
	logic [DIM_BITS-1:0] y_q;
	logic [DIM_BITS-1:0] w_q;
	logic [DIM_BITS-1:0] h_q;

	assign mode = cap_pkg::mode_t'(side_in[SIDE_W-1 -: cap_pkg::MODE_W]);
	assign aw = side_in[2*DIM_BITS -: DIM_BITS];
	assign ah = side_in[DIM_BITS -: DIM_BITS];
	assign fit_h = side_in[0];

	always_comb begin
		ok = 1'b0;
		w = '0;
		h = '0;
		ax = cap_pkg::ALIGN_START;
		ay = cap_pkg::ALIGN_START;
		case (mode)
			cap_pkg::MODE_STRETCH: begin
				ok = 1'b1;
				w = canvas_w;
				h = canvas_h;
			end
			cap_pkg::MODE_FIT_CENTRE, cap_pkg::MODE_FIT_LEFT, cap_pkg::MODE_FIT_RIGHT,
			cap_pkg::MODE_FIT_TOP, cap_pkg::MODE_FIT_BOTTOM: begin
				ok = (aw != '0) && (ah != '0);
				w = fit_h ? quo_in : canvas_w;
				h = fit_h ? canvas_h : quo_in;
				ax = cap_pkg::ALIGN_MID;
				ay = cap_pkg::ALIGN_MID;
				if (mode == cap_pkg::MODE_FIT_LEFT) begin
					ax = cap_pkg::ALIGN_START;
				end else if (mode == cap_pkg::MODE_FIT_RIGHT) begin
					ax = cap_pkg::ALIGN_END;
				end else if (mode == cap_pkg::MODE_FIT_TOP) begin
					ay = cap_pkg::ALIGN_START;
				end else if (mode == cap_pkg::MODE_FIT_BOTTOM) begin
					ay = cap_pkg::ALIGN_END;
				end
			end
			cap_pkg::MODE_TOP_LEFT, cap_pkg::MODE_TOP_CENTRE, cap_pkg::MODE_TOP_RIGHT,
			cap_pkg::MODE_MID_LEFT, cap_pkg::MODE_CENTRE, cap_pkg::MODE_MID_RIGHT,
			cap_pkg::MODE_BOTTOM_LEFT, cap_pkg::MODE_BOTTOM_CENTRE,
			cap_pkg::MODE_BOTTOM_RIGHT: begin
				ok = (aw <= canvas_w) && (ah <= canvas_h);
				w = aw;
				h = ah;
				case (mode)
					cap_pkg::MODE_TOP_CENTRE, cap_pkg::MODE_CENTRE,
					cap_pkg::MODE_BOTTOM_CENTRE: ax = cap_pkg::ALIGN_MID;
					cap_pkg::MODE_TOP_RIGHT, cap_pkg::MODE_MID_RIGHT,
					cap_pkg::MODE_BOTTOM_RIGHT: ax = cap_pkg::ALIGN_END;
					default: ax = cap_pkg::ALIGN_START;
				endcase
				case (mode)
					cap_pkg::MODE_MID_LEFT, cap_pkg::MODE_CENTRE,
					cap_pkg::MODE_MID_RIGHT: ay = cap_pkg::ALIGN_MID;
					cap_pkg::MODE_BOTTOM_LEFT, cap_pkg::MODE_BOTTOM_CENTRE,
					cap_pkg::MODE_BOTTOM_RIGHT: ay = cap_pkg::ALIGN_END;
					default: ay = cap_pkg::ALIGN_START;
				endcase
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		case (ax)
			cap_pkg::ALIGN_MID: x = (canvas_w >> 1) - (w >> 1);
			cap_pkg::ALIGN_END: x = canvas_w - w;
			default:            x = '0;
		endcase
		case (ay)
			cap_pkg::ALIGN_MID: y = (canvas_h >> 1) - (h >> 1);
			cap_pkg::ALIGN_END: y = canvas_h - h;
			default:            y = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// A rejected transaction reports an all-zero rectangle.
	always_ff @(posedge clk) begin
		if (en) begin
			ok_q <= ok;
			x_q <= ok ? x : '0;
			y_q <= ok ? y : '0;
			w_q <= ok ? w : '0;
			h_q <= ok ? h : '0;
		end
	end

	assign res.valid = valid_q;
	assign res.placed_ok = ok_q;
	assign res.pos_x = x_q;
	assign res.pos_y = y_q;
	assign res.placed_width = w_q;
	assign res.placed_height = h_q;

endmodule
`default_nettype wire

// ===== src/canvas_asset_placement.sv =====
// Requests pass through stage 1, stage 2, a row of DIM_BITS divider cells and the final stage.
// Throughput: one transaction per cycle unless the output stalls; each of the DIM_BITS cells
// settles one quotient bit and passes its work to the next cell each time the pipeline advances.
// The whole pipeline holds while a finished result waits on the output.
// Reset clears all valid bits and sets the canvas to 1920 by 1080.
`default_nettype none
module canvas_asset_placement #(
	parameter int DIM_BITS = cap_pkg::DIM_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cap_req_if.sink                             req,
	cap_res_if.source                           res,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cap_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [cap_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [cap_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	localparam int PROD_W = 2*DIM_BITS;
	localparam int SIDE_W = cap_pkg::MODE_W + 2*DIM_BITS + 1;

	logic [DIM_BITS-1:0]        canvas_w_q;
	logic [DIM_BITS-1:0]        canvas_h_q;
	logic                       cfg_wr;
	logic                       adv;

	logic                       valid_s1;
	logic [cap_pkg::MODE_W-1:0] mode_s1;
	logic [DIM_BITS-1:0]        aw_s1;
	logic [DIM_BITS-1:0]        ah_s1;
	logic [PROD_W-1:0]          cw_ah_s1;
	logic [PROD_W-1:0]          aw_ch_s1;

	logic                       fit_h;
	logic                       valid_s2;
	logic [PROD_W-1:0]          num_s2;
	logic [DIM_BITS-1:0]        div_s2;
	logic [SIDE_W-1:0]          side_s2;

	logic                       valid_c [DIM_BITS+1];
	logic [PROD_W-1:0]          rem_c   [DIM_BITS+1];
	logic [DIM_BITS-1:0]        div_c   [DIM_BITS+1];
	logic [DIM_BITS-1:0]        quo_c   [DIM_BITS+1];
	logic [SIDE_W-1:0]          side_c  [DIM_BITS+1];

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= DIM_BITS'(cap_pkg::CANVAS_W_RESET);
			canvas_h_q <= DIM_BITS'(cap_pkg::CANVAS_H_RESET);
		end else if (cfg_wr) begin
			if (paddr[2] == cap_pkg::REG_CANVAS_W) begin
				canvas_w_q <= pwdata[DIM_BITS-1:0];
			end else begin
				canvas_h_q <= pwdata[DIM_BITS-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			cap_pkg::REG_CANVAS_W: prdata = cap_pkg::APB_DATA_W'(canvas_w_q);
			cap_pkg::REG_CANVAS_H: prdata = cap_pkg::APB_DATA_W'(canvas_h_q);
			default:               prdata = '0;
		endcase
	end

	// Every stage moves together unless the output holds a result not yet taken.
	assign adv = !res.valid || res.ready;
	assign req.ready = adv;

	// Stage 1: cross products of the two aspect ratios.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= req.align_mode;
			aw_s1 <= req.asset_width;
			ah_s1 <= req.asset_height;
			cw_ah_s1 <= PROD_W'(canvas_w_q) * PROD_W'(req.asset_height);
			aw_ch_s1 <= PROD_W'(req.asset_width) * PROD_W'(canvas_h_q);
		end
	end

	// Stage 2: choose the limiting axis and set up the division.
	assign fit_h = cw_ah_s1 > aw_ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= fit_h ? aw_ch_s1 : cw_ah_s1;
			div_s2 <= fit_h ? ah_s1 : aw_s1;
			side_s2 <= {mode_s1, aw_s1, ah_s1, fit_h};
		end
	end

	assign valid_c[0] = valid_s2;
	assign rem_c[0] = num_s2;
	assign div_c[0] = div_s2;
	assign quo_c[0] = '0;
	assign side_c[0] = side_s2;

	// The quotient never exceeds the canvas side, so DIM_BITS cells cover it.
	for (genvar k = 0; k < DIM_BITS; k++) begin : g_cell
		cap_div_cell #(
			.DIM_BITS (DIM_BITS),
			.SIDE_W   (SIDE_W),
			.BIT_POS  (DIM_BITS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (valid_c[k]),
			.rem_in    (rem_c[k]),
			.div_in    (div_c[k]),
			.quo_in    (quo_c[k]),
			.side_in   (side_c[k]),
			.valid_out (valid_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.div_out   (div_c[k+1]),
			.quo_out   (quo_c[k+1]),
			.side_out  (side_c[k+1])
		);
	end

	cap_place #(
		.DIM_BITS (DIM_BITS),
		.SIDE_W   (SIDE_W)
	) u_place (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_in (valid_c[DIM_BITS]),
		.quo_in   (quo_c[DIM_BITS]),
		.side_in  (side_c[DIM_BITS]),
		.canvas_w (canvas_w_q),
		.canvas_h (canvas_h_q),
		.res      (res)
	);

endmodule
`default_nettype wire

// ===== dv/canvas_asset_placement_tb.sv =====
`default_nettype none
module canvas_asset_placement_tb;
	import cap_pkg::*;

	localparam int DIM = DIM_BITS_DEF;
	localparam int DIM_MAX = (1 << DIM) - 1;
	localparam int LATENCY = DIM + 3;

	typedef logic [DIM-1:0] dim_t;

	typedef struct packed {
		mode_t mode;
		dim_t  width;
		dim_t  height;
	} place_req_t;

	typedef struct packed {
		logic ok;
		dim_t x;
		dim_t y;
		dim_t w;
		dim_t h;
	} placement_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        req_valid = 1'b0;
	mode_t       req_mode = MODE_STRETCH;
	dim_t        req_width = '0;
	dim_t        req_height = '0;
	logic        res_ready = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cap_req_if #(.DIM_BITS(DIM)) req_bus ();
	cap_res_if #(.DIM_BITS(DIM)) res_bus ();

	assign req_bus.valid        = req_valid;
	assign req_bus.align_mode   = req_mode;
	assign req_bus.asset_width  = req_width;
	assign req_bus.asset_height = req_height;
	assign res_bus.ready        = res_ready;

	canvas_asset_placement #(.DIM_BITS(DIM)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Local copy of the canvas registers, updated once each write has completed.
	dim_t canvas_w = dim_t'(CANVAS_W_RESET);
	dim_t canvas_h = dim_t'(CANVAS_H_RESET);

	place_req_t requests_pending[$];
	placement_t placements_due[$];
	place_req_t cur_req;
	int         send_gap = 0;
	int         stall_left = 0;
	logic       tx_idle_en = 1'b1;
	logic       rx_idle_en = 1'b1;
	int         fail_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint unsigned centre_off(longint unsigned c, longint unsigned s);
		return c / 2 - s / 2;
	endfunction

	function automatic placement_t place_asset(place_req_t r);
		placement_t p;
		longint unsigned cw, ch, aw, ah, x, y, w, h;
		int idx;
		align_t col, row;
		logic ok;
		cw = canvas_w;
		ch = canvas_h;
		aw = r.width;
		ah = r.height;
		x = 0;
		y = 0;
		w = 0;
		h = 0;
		ok = 1'b1;
		if (r.mode == MODE_STRETCH) begin
			w = cw;
			h = ch;
		end else if (r.mode <= MODE_FIT_BOTTOM) begin
			if (aw == 0 || ah == 0) begin
				ok = 1'b0;
			end else begin
				// Exact cross-multiplied aspect comparison; a tie fits to the width.
				if (cw * ah > aw * ch) begin
					h = ch;
					w = (aw * ch) / ah;
				end else begin
					w = cw;
					h = (ah * cw) / aw;
				end
				x = centre_off(cw, w);
				y = centre_off(ch, h);
				case (r.mode)
					MODE_FIT_LEFT:   x = 0;
					MODE_FIT_RIGHT:  x = cw - w;
					MODE_FIT_TOP:    y = 0;
					MODE_FIT_BOTTOM: y = ch - h;
					default: ;
				endcase
			end
		end else if (r.mode <= MODE_BOTTOM_RIGHT) begin
			if (aw > cw || ah > ch) begin
				ok = 1'b0;
			end else begin
				idx = int'(r.mode) - int'(MODE_TOP_LEFT);
				col = align_t'(idx % 3);
				row = align_t'(idx / 3);
				w = aw;
				h = ah;
				case (col)
					ALIGN_START: x = 0;
					ALIGN_MID:   x = centre_off(cw, aw);
					default:     x = cw - aw;
				endcase
				case (row)
					ALIGN_START: y = 0;
					ALIGN_MID:   y = centre_off(ch, ah);
					default:     y = ch - ah;
				endcase
			end
		end else begin
			ok = 1'b0;
		end
		if (!ok) begin
			x = 0;
			y = 0;
			w = 0;
			h = 0;
		end
		p.ok = ok;
		p.x = dim_t'(x);
		p.y = dim_t'(y);
		p.w = dim_t'(w);
		p.h = dim_t'(h);
		return p;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sizes cluster round the canvas edge so that fit and reject both occur often.
	function automatic dim_t pick_dim(int unsigned c);
		int unsigned d;
		case ($urandom_range(0, 9))
			0:          d = 0;
			1:          d = c;
			2:          d = (c < DIM_MAX) ? c + 1 : c;
			3, 4, 5, 6: d = $urandom_range(0, c);
			7:          d = $urandom_range(1, 16);
			default:    d = $urandom_range(0, DIM_MAX);
		endcase
		return dim_t'(d);
	endfunction

	task automatic queue_req(mode_t m, int unsigned aw, int unsigned ah);
		place_req_t r;
		r.mode = m;
		r.width = dim_t'(aw);
		r.height = dim_t'(ah);
		requests_pending.push_back(r);
	endtask

	task automatic write_canvas(logic reg_idx, int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_CANVAS_W)
			canvas_w = dim_t'(value);
		else
			canvas_h = dim_t'(value);
	endtask

	// Sender holds off until every placement in flight has come back.
	task automatic drain();
		@(negedge clk);
		while (requests_pending.size() != 0 || req_valid || placements_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int unsigned cw, int unsigned ch, int n, logic idle_on);
		drain();
		tx_idle_en = idle_on && ($urandom_range(0, 3) != 0);
		rx_idle_en = idle_on && ($urandom_range(0, 3) != 0);
		write_canvas(REG_CANVAS_W, cw);
		write_canvas(REG_CANVAS_H, ch);
		@(negedge clk);
		repeat (n)
			queue_req(mode_t'($urandom_range(0, 15)), pick_dim(canvas_w), pick_dim(canvas_h));
	endtask

	task automatic report_field(string name, int unsigned want, int unsigned got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_bus.ready) begin
			if (req_valid)
				placements_due.push_back(place_asset(cur_req));
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (requests_pending.size() != 0) begin
				cur_req = requests_pending.pop_front();
				req_mode <= cur_req.mode;
				req_width <= cur_req.width;
				req_height <= cur_req.height;
				req_valid <= 1'b1;
				if (tx_idle_en)
					send_gap = pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		placement_t got, want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_ready && res_bus.valid) begin
				got.ok = res_bus.placed_ok;
				got.x = res_bus.pos_x;
				got.y = res_bus.pos_y;
				got.w = res_bus.placed_width;
				got.h = res_bus.placed_height;
				if (placements_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got %p", $time, got);
				end else begin
					want = placements_due.pop_front();
					if (got.ok !== want.ok)
						report_field("placed_ok", want.ok, got.ok);
					if (got.x !== want.x)
						report_field("pos_x", want.x, got.x);
					if (got.y !== want.y)
						report_field("pos_y", want.y, got.y);
					if (got.w !== want.w)
						report_field("placed_width", want.w, got.w);
					if (got.h !== want.h)
						report_field("placed_height", want.h, got.h);
				end
			end
			if (rx_idle_en && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every mode once on the reset canvas, then the corner cases.
		for (int m = 0; m < 16; m++)
			queue_req(mode_t'(m), 800, 600);
		queue_req(MODE_FIT_CENTRE, 4000, 1000);
		queue_req(MODE_FIT_RIGHT, 16, 9);
		queue_req(MODE_FIT_LEFT, 0, 100);
		queue_req(MODE_FIT_TOP, 100, 0);
		queue_req(MODE_CENTRE, 0, 0);
		queue_req(MODE_TOP_LEFT, CANVAS_W_RESET + 1, CANVAS_H_RESET);
		queue_req(MODE_BOTTOM_CENTRE, CANVAS_W_RESET, CANVAS_H_RESET + 1);
		queue_req(MODE_BOTTOM_RIGHT, CANVAS_W_RESET, CANVAS_H_RESET);
		queue_req(MODE_FIT_CENTRE, DIM_MAX, 1);
		queue_req(MODE_FIT_BOTTOM, 1, DIM_MAX);

		run_phase(1920, 1080, 200, 1'b1);
		run_phase(1, 1, 200, 1'b0);
		run_phase(DIM_MAX, DIM_MAX, 200, 1'b1);
		run_phase(DIM_MAX, 1, 200, 1'b1);
		run_phase(1, DIM_MAX, 200, 1'b1);
		// A zero canvas side is used as written.
		run_phase(0, 1080, 30, 1'b1);
		run_phase(1920, 0, 30, 1'b1);
		for (int i = 0; i < 3; i++)
			run_phase($urandom_range(1, DIM_MAX), $urandom_range(1, DIM_MAX), 200, 1'b1);
		run_phase(1280, 720, 200, 1'b1);

		drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== canvas_asset_placement.f =====
src/cap_pkg.sv
src/cap_req_if.sv
src/cap_res_if.sv
src/cap_div_cell.sv
src/cap_place.sv
src/canvas_asset_placement.sv
dv/canvas_asset_placement_tb.sv
